>>> src/deque_with_undo_log_assert.svh
// ---------------------------------------------------------------------------
// deque assertion macros
// shared concurrent assertion forms for the deque block
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_UNDO_LOG_ASSERT_SVH
`define DEQUE_WITH_UNDO_LOG_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DQU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, disabled during reset
`define DQU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

>>> src/dqu_pkg.sv
// ---------------------------------------------------------------------------
// deque package
// request and response types, mode, kind and status codes
// ---------------------------------------------------------------------------
`default_nettype none

package dqu_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic [31:0] front_value;
        logic [31:0] back_value;
    } t_rsp;

    localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_POP_BACK   = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_UNDO       = 3'd4;

    localparam logic [1:0] KIND_PUSH_BACK  = 2'd0;
    localparam logic [1:0] KIND_PUSH_FRONT = 2'd1;
    localparam logic [1:0] KIND_POP_BACK   = 2'd2;
    localparam logic [1:0] KIND_POP_FRONT  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NOHIST = 2'd3;

endpackage

`default_nettype wire

>>> src/deque_with_undo_log.sv
// ---------------------------------------------------------------------------
// deque with undo log
// order: a request is captured in the request register, then processed into the
//   state and response registers, and its response strobe rises with them
// throughput: one request per cycle, busy stays low; end values come from
//   held registers and neighbor entries prefetched over two memory read ports
// reset: synchronous active low, empty queue and empty history, no clearing
//   pass; the receiver cannot stall, every response shows for one cycle
// ---------------------------------------------------------------------------
`default_nettype none

`include "deque_with_undo_log_assert.svh"

module deque_with_undo_log #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int HISTORY_DEPTH = 16,
    parameter int DATA_WIDTH    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dqu_pkg::t_req i_req,
    output logic               o_strobe,
    output dqu_pkg::t_rsp      o_rsp
);

    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int RW  = DATA_WIDTH + 2;

    localparam logic [QW-1:0]  Q_LAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [HW-1:0]  H_LAST = HW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0]  Q_FULL = CW'(QUEUE_DEPTH);
    localparam logic [HCW-1:0] H_FULL = HCW'(HISTORY_DEPTH);

    // ring pointer steps, depth need not be a power of two
    function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] x);
        return (x == Q_LAST) ? '0 : x + QW'(1);
    endfunction

    function automatic logic [QW-1:0] q_dec(input logic [QW-1:0] x);
        return (x == '0) ? Q_LAST : x - QW'(1);
    endfunction

    function automatic logic [HW-1:0] h_inc(input logic [HW-1:0] x);
        return (x == H_LAST) ? '0 : x + HW'(1);
    endfunction

    function automatic logic [HW-1:0] h_dec(input logic [HW-1:0] x);
        return (x == '0) ? H_LAST : x - HW'(1);
    endfunction

    // request register
    logic          r_req_vld;
    dqu_pkg::t_req r_req;

    // queue state; r_back always equals front + count - 1 around the ring
    logic [QW-1:0]         r_front, n_front;
    logic [QW-1:0]         r_back, n_back;
    logic [CW-1:0]         r_count, n_count;
    logic [DATA_WIDTH-1:0] r_fv, n_fv;     // value at the front slot
    logic [DATA_WIDTH-1:0] r_bv, n_bv;     // value at the back slot

    // history state
    logic [HW-1:0]  r_htop, n_htop;
    logic [HCW-1:0] r_hcount, n_hcount;

    // response register
    logic          r_strobe;
    dqu_pkg::t_rsp r_rsp, n_rsp;

    // memory ports
    logic                  q_we;
    logic [QW-1:0]         q_waddr;
    logic [DATA_WIDTH-1:0] q_wdata;
    logic [DATA_WIDTH-1:0] f1_data;        // entry just inside the front
    logic [DATA_WIDTH-1:0] b1_data;        // entry just inside the back
    logic                  h_we;
    logic [RW-1:0]         h_wdata;
    logic [RW-1:0]         h_rec;          // newest history record

    // step decode
    logic [1:0]            op_kind;
    logic [DATA_WIDTH-1:0] op_val;
    logic [DATA_WIDTH-1:0] removed;
    logic                  do_op;
    logic                  record;
    logic [1:0]            status;

    assign busy = 1'b0;

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_fv     = r_fv;
        n_bv     = r_bv;
        n_htop   = r_htop;
        n_hcount = r_hcount;
        q_we     = 1'b0;
        q_waddr  = r_front;
        h_we     = 1'b0;
        op_kind  = dqu_pkg::KIND_PUSH_BACK;
        op_val   = DATA_WIDTH'(r_req.value);
        removed  = '0;
        do_op    = 1'b0;
        record   = 1'b0;
        status   = dqu_pkg::ST_OK;

        // pick the operation: a plain request, or the inverse of the newest record
        if (r_req_vld) begin
            if (r_req.mode <= dqu_pkg::MODE_POP_FRONT) begin
                op_kind = r_req.mode[1:0];
                do_op   = 1'b1;
                record  = 1'b1;
            end else if (r_req.mode == dqu_pkg::MODE_UNDO) begin
                if (r_hcount == '0) begin
                    status = dqu_pkg::ST_NOHIST;
                end else begin
                    do_op  = 1'b1;
                    op_val = h_rec[DATA_WIDTH-1:0];
                    unique case (h_rec[RW-1 -: 2])
                        dqu_pkg::KIND_PUSH_BACK:  op_kind = dqu_pkg::KIND_POP_BACK;
                        dqu_pkg::KIND_PUSH_FRONT: op_kind = dqu_pkg::KIND_POP_FRONT;
                        dqu_pkg::KIND_POP_BACK:   op_kind = dqu_pkg::KIND_PUSH_BACK;
                        default:                  op_kind = dqu_pkg::KIND_PUSH_FRONT;
                    endcase
                end
            end
        end

        // apply it to the ring; end values come from registers or neighbors
        if (do_op) begin
            if (!op_kind[1]) begin
                if (r_count == Q_FULL) begin
                    status = dqu_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    q_we    = 1'b1;
                    if (op_kind == dqu_pkg::KIND_PUSH_BACK) begin
                        n_back  = q_inc(r_back);
                        q_waddr = n_back;
                        n_bv    = op_val;
                        if (r_count == '0) begin
                            n_fv = op_val;
                        end
                    end else begin
                        n_front = q_dec(r_front);
                        q_waddr = n_front;
                        n_fv    = op_val;
                        if (r_count == '0) begin
                            n_bv = op_val;
                        end
                    end
                end
            end else begin
                if (r_count == '0) begin
                    status = dqu_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                    if (op_kind == dqu_pkg::KIND_POP_BACK) begin
                        removed = r_bv;
                        n_back  = q_dec(r_back);
                        n_bv    = b1_data;
                    end else begin
                        removed = r_fv;
                        n_front = q_inc(r_front);
                        n_fv    = f1_data;
                    end
                end
            end

            // history bookkeeping on success only
            if (status == dqu_pkg::ST_OK) begin
                if (record) begin
                    h_we   = 1'b1;
                    n_htop = h_inc(r_htop);
                    if (r_hcount != H_FULL) begin
                        n_hcount = r_hcount + HCW'(1);
                    end
                end else begin
                    n_htop   = h_dec(r_htop);
                    n_hcount = r_hcount - HCW'(1);
                end
            end
        end

        q_wdata = op_val;
        h_wdata = {op_kind, removed};

        n_rsp.status      = status;
        n_rsp.entry_count = 5'(n_count);
        n_rsp.front_value = (n_count == '0) ? 32'd0 : 32'(n_fv);
        n_rsp.back_value  = (n_count == '0) ? 32'd0 : 32'(n_bv);
    end

    // neighbor prefetch follows the next front and back pointers
    dqu_entry_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (QW),
        .WIDTH  (DATA_WIDTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_we      (q_we),
        .i_waddr   (q_waddr),
        .i_wdata   (q_wdata),
        .i_raddr_a (q_inc(n_front)),
        .i_raddr_b (q_dec(n_back)),
        .o_rdata_a (f1_data),
        .o_rdata_b (b1_data)
    );

    // newest record always sits one slot below the next top
    dqu_hist_ram #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (HW),
        .WIDTH  (RW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (r_htop),
        .i_wdata (h_wdata),
        .i_raddr (h_dec(n_htop)),
        .o_rdata (h_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_strobe  <= 1'b0;
            r_front   <= '0;
            r_back    <= Q_LAST;
            r_count   <= '0;
            r_htop    <= '0;
            r_hcount  <= '0;
        end else begin
            r_req_vld <= start && !busy;
            r_strobe  <= r_req_vld;
            r_front   <= n_front;
            r_back    <= n_back;
            r_count   <= n_count;
            r_htop    <= n_htop;
            r_hcount  <= n_hcount;
        end
        // payload registers
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_fv  <= n_fv;
        r_bv  <= n_bv;
        r_rsp <= n_rsp;
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // a processed request always produces a response strobe
    `DQU_ASSERT_NEXT(a_rsp_follows, i_clk, i_rst_n, r_req_vld, r_strobe)
    // full status only when the queue really is full
    `DQU_ASSERT_SAME(a_full_count, i_clk, i_rst_n,
        r_strobe && (r_rsp.status == dqu_pkg::ST_FULL), r_count == Q_FULL)
    // empty status only when the queue really is empty
    `DQU_ASSERT_SAME(a_empty_count, i_clk, i_rst_n,
        r_strobe && (r_rsp.status == dqu_pkg::ST_EMPTY), r_count == '0)
    // no-history status only with an empty history
    `DQU_ASSERT_SAME(a_nohist_count, i_clk, i_rst_n,
        r_strobe && (r_rsp.status == dqu_pkg::ST_NOHIST), r_hcount == '0)

endmodule

`default_nettype wire

>>> src/dqu_entry_ram.sv
// ---------------------------------------------------------------------------
// deque entry memory
// one write port, two registered read ports with write bypass
// ---------------------------------------------------------------------------
`default_nettype none

module dqu_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WIDTH  = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]  o_rdata_a,
    output logic      [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // same-edge write wins over the old contents
        if (i_we && (i_waddr == i_raddr_a)) begin
            r_rdata_a <= i_wdata;
        end else begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_we && (i_waddr == i_raddr_b)) begin
            r_rdata_b <= i_wdata;
        end else begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

>>> src/dqu_hist_ram.sv
// ---------------------------------------------------------------------------
// deque history memory
// one write port, one registered read port with write bypass
// ---------------------------------------------------------------------------
`default_nettype none

module dqu_hist_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WIDTH  = 34
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
